>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CMD_W    = 1;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 11;
	localparam int CELL_W   = 16;
	localparam int CURSOR_W = 11;

	localparam logic [CMD_W-1:0]  CMD_PUT  = 1'b0;
	localparam logic [CMD_W-1:0]  CMD_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

	localparam logic [CHAR_W-1:0] ATTR_GRAY  = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_READ,
		OP_CHAR,
		OP_LF
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [CHAR_W-1:0]   char_code;
		logic [INDEX_W-1:0]  cell_index;
	} op_t;

endpackage

>>> rtl/core/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: command, character and cell index with valid and ready.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [CHAR_W-1:0]   char_code;
	logic [INDEX_W-1:0]  cell_index;

	modport source (output valid, output cmd, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input cmd, input char_code, input cell_index,
		output ready);

endinterface

>>> rtl/core/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cell value and cursor position with valid and ready.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [CELL_W-1:0]    cell_value;
	logic [CURSOR_W-1:0]  cursor_pos;

	modport source (output valid, output cell_value, output cursor_pos, input ready);
	modport sink (input valid, input cell_value, input cursor_pos, output ready);

endinterface

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console of COLUMNS x ROWS 16-bit cells with a cursor.
// ----------------------------------------------------------------------------
// The request channel carries a command: put prints one character, read
// returns one stored cell, or zero for an index beyond the screen. Every
// request gives exactly one response on the response channel, with the cell
// value (zero for put) and the cursor after the request, in request order.
// A request that needs no walk over cells (read, carriage return, plain
// character) sustains one transfer per cycle while the response receiver
// keeps up; its response is registered after it leaves the queue.
// A line feed writes one blank cell per cycle up to the end of the row. A
// put at the end of the screen first primes a read and then scrolls the
// cell store one cell per cycle, using its separate write and read ports.
// After reset the store is cleared to blank cells, during which request
// ready stays low. A two-entry queue decouples the front end from
// execution; when the response receiver stalls, the finished response is
// held and execution waits, and the queue fills before request ready drops.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_req_if.sink     request,
	tcw_rsp_if.source   response
);

	logic  op_valid;
	op_t   op;
	logic  op_ready;
	logic  init_done;

	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.init_done (init_done),
		.op_valid  (op_valid),
		.op        (op),
		.op_ready  (op_ready)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_ready  (op_ready),
		.init_done (init_done),
		.response  (response)
	);

endmodule

>>> rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, classifies them into operations and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_req_if.sink     request,
	input  logic        init_done,
	output logic        op_valid,
	output op_t         op,
	input  logic        op_ready
);

	localparam int NCELLS = COLUMNS * ROWS;

	op_t        queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        op_new;
	logic       push;
	logic       pop;

	always_comb begin
		op_new.char_code  = request.char_code;
		op_new.cell_index = request.cell_index;
		if (request.cmd == CMD_READ) begin
			op_new.kind = (32'(request.cell_index) < NCELLS) ? OP_READ : OP_NOP;
		end else if (request.char_code == CH_CR) begin
			op_new.kind = OP_NOP;
		end else if (request.char_code == CH_LF) begin
			op_new.kind = OP_LF;
		end else begin
			op_new.kind = OP_CHAR;
		end
	end

	assign request.ready = init_done && (count_q != 2'd2);
	assign push          = request.valid && request.ready;
	assign op_valid      = (count_q != 2'd0);
	assign pop           = op_valid && op_ready;
	assign op            = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued operations on the cell store and cursor: reads, character
// writes, line feed fills, scrolling and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  op_t         op,
	output logic        op_ready,
	output logic        init_done,
	tcw_rsp_if.source   response
);

	localparam int NCELLS = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(NCELLS);
	localparam int CUR_W  = $clog2(NCELLS + 1);
	localparam int COL_W  = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRIME,
		ST_SCROLL,
		ST_FILL
	} state_t;

	state_t               state_q, state_n;
	logic [CUR_W-1:0]     cursor_q, cursor_n;
	logic [COL_W-1:0]     col_q, col_n;
	logic [ADDR_W-1:0]    cnt_q, cnt_n;
	logic                 valid_s2;
	logic                 is_read_s2;
	logic [CURSOR_W-1:0]  cursor_s2;

	logic [CELL_W-1:0]    cells_q [NCELLS];
	logic [CELL_W-1:0]    rdata_q;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [CELL_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;

	logic                 s2_free;
	logic                 load_s2;
	logic                 read_n;
	logic                 at_end;
	logic                 row_end;
	logic [CUR_W-1:0]     cursor_inc;
	logic [COL_W-1:0]     col_inc;
	logic [ADDR_W:0]      cnt_nx;

	assign s2_free    = !valid_s2 || response.ready;
	assign at_end     = (cursor_q == CUR_W'(NCELLS));
	assign row_end    = (col_q == COL_W'(COLUMNS - 1));
	assign cursor_inc = cursor_q + CUR_W'(1);
	assign col_inc    = row_end ? '0 : col_q + COL_W'(1);
	assign cnt_nx     = {1'b0, cnt_q} + (ADDR_W + 1)'(1);
	assign init_done  = (state_q != ST_CLEAR);

	always_comb begin
		state_n   = state_q;
		cursor_n  = cursor_q;
		col_n     = col_q;
		cnt_n     = cnt_q;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(cursor_q);
		mem_wdata = BLANK_CELL;
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(op.cell_index);
		op_ready  = 1'b0;
		load_s2   = 1'b0;
		read_n    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				if (cnt_q == ADDR_W'(NCELLS - 1)) begin
					state_n = ST_IDLE;
					cnt_n   = '0;
				end else begin
					cnt_n = cnt_nx[ADDR_W-1:0];
				end
			end
			ST_IDLE: begin
				if (op_valid && s2_free) begin
					unique case (op.kind)
						OP_NOP: begin
							op_ready = 1'b1;
							load_s2  = 1'b1;
						end
						OP_READ: begin
							mem_re   = 1'b1;
							op_ready = 1'b1;
							load_s2  = 1'b1;
							read_n   = 1'b1;
						end
						OP_CHAR: begin
							if (at_end) begin
								state_n = ST_PRIME;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = {ATTR_GRAY, op.char_code};
								cursor_n  = cursor_inc;
								col_n     = col_inc;
								op_ready  = 1'b1;
								load_s2   = 1'b1;
							end
						end
						OP_LF: begin
							if (at_end) begin
								state_n = ST_PRIME;
							end else begin
								mem_we   = 1'b1;
								cursor_n = cursor_inc;
								col_n    = col_inc;
								if (row_end) begin
									op_ready = 1'b1;
									load_s2  = 1'b1;
								end else begin
									state_n = ST_FILL;
								end
							end
						end
					endcase
				end
			end
			ST_PRIME: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(COLUMNS);
				cnt_n     = '0;
				state_n   = ST_SCROLL;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = ({1'b0, cnt_q} < (ADDR_W + 1)'(NCELLS - COLUMNS)) ?
					rdata_q : BLANK_CELL;
				mem_raddr = ADDR_W'(cnt_nx + (ADDR_W + 1)'(COLUMNS));
				mem_re    = (cnt_nx < (ADDR_W + 1)'(NCELLS - COLUMNS));
				if (cnt_q == ADDR_W'(NCELLS - 1)) begin
					cursor_n = CUR_W'(NCELLS - COLUMNS);
					col_n    = '0;
					cnt_n    = '0;
					state_n  = ST_IDLE;
				end else begin
					cnt_n = cnt_nx[ADDR_W-1:0];
				end
			end
			ST_FILL: begin
				mem_we   = 1'b1;
				cursor_n = cursor_inc;
				col_n    = col_inc;
				if (row_end) begin
					op_ready = 1'b1;
					load_s2  = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= cells_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cursor_q   <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
			valid_s2   <= 1'b0;
			is_read_s2 <= 1'b0;
			cursor_s2  <= '0;
		end else begin
			state_q  <= state_n;
			cursor_q <= cursor_n;
			col_q    <= col_n;
			cnt_q    <= cnt_n;
			if (load_s2) begin
				valid_s2   <= 1'b1;
				is_read_s2 <= read_n;
				cursor_s2  <= CURSOR_W'(cursor_n);
			end else if (response.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign response.valid      = valid_s2;
	assign response.cell_value = is_read_s2 ? rdata_q : '0;
	assign response.cursor_pos = cursor_s2;

endmodule
